@@ rtl/pcpe_pkg.sv @@
package pcpe_pkg;

  // Coordinate and curve-position formats
  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned T_FRAC_BITS = 16;

  // Doubled power-basis coefficient width (worst case is 24x a point)
  localparam int unsigned KW = COORD_WIDTH + 6;
  // Horner accumulator width, holds k3*t^3 + ... + k0*S^3 exactly
  localparam int unsigned AW = KW + 3 * T_FRAC_BITS + 3;
  // Split point of the accumulator for the partial products
  localparam int unsigned AH = AW / 2;
  // Final scaling shift: divide by 2 * S^3
  localparam int unsigned SH = 3 * T_FRAC_BITS + 1;
  // Width of the scaled result before saturation
  localparam int unsigned QW = AW - SH;

  typedef enum logic [1:0] {
    CK_LINE    = 2'd0,
    CK_QUAD    = 2'd1,
    CK_CUBIC   = 2'd2,
    CK_CATMULL = 2'd3
  } curve_kind_e;

  // Data that travels with one transaction through the Horner stages
  typedef struct packed {
    logic signed [KW-1:0]          k3;
    logic signed [KW-1:0]          k2;
    logic signed [KW-1:0]          k1;
    logic signed [KW-1:0]          k0;
    logic [T_FRAC_BITS-1:0]        t;
    logic                          special;
    logic signed [COORD_WIDTH-1:0] spec_val;
  } coef_t;

  // Data handed from the Horner chain to the rounding stage
  typedef struct packed {
    logic signed [AW-1:0]          acc;
    logic                          special;
    logic signed [COORD_WIDTH-1:0] spec_val;
  } poly_t;

  function automatic logic signed [KW-1:0] sext_pt(input logic [COORD_WIDTH-1:0] p);
    return {{(KW - COORD_WIDTH){p[COORD_WIDTH-1]}}, p};
  endfunction

endpackage

@@ rtl/pcpe_coef.sv @@
module pcpe_coef import pcpe_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [1:0]                    curve_kind_i,
  input  logic [T_FRAC_BITS:0]          param_t_i,
  input  logic signed [COORD_WIDTH-1:0] pt_start_i,
  input  logic signed [COORD_WIDTH-1:0] pt_ctrl_a_i,
  input  logic signed [COORD_WIDTH-1:0] pt_ctrl_b_i,
  input  logic signed [COORD_WIDTH-1:0] pt_end_i,
  output logic                          valid_o,
  output coef_t                         coef_o
);

  logic signed [KW-1:0] ps, pa, pb, pe;
  logic signed [KW-1:0] pa3, pb3, ps3, pe3;
  logic signed [KW-1:0] d2;
  coef_t                coef_d, coef_q;
  logic                 valid_q;

  assign ps  = sext_pt(pt_start_i);
  assign pa  = sext_pt(pt_ctrl_a_i);
  assign pb  = sext_pt(pt_ctrl_b_i);
  assign pe  = sext_pt(pt_end_i);
  assign pa3 = (pa <<< 1) + pa;
  assign pb3 = (pb <<< 1) + pb;
  assign ps3 = (ps <<< 1) + ps;
  assign pe3 = (pe <<< 1) + pe;

  always_comb begin
    coef_d    = '0;
    coef_d.k0 = ps <<< 1;
    d2        = '0;
    case (curve_kind_e'(curve_kind_i))
      CK_LINE: begin
        coef_d.k1 = (pe - ps) <<< 1;
      end
      CK_QUAD: begin
        coef_d.k1 = (pa - ps) <<< 2;
        coef_d.k2 = (ps - (pa <<< 1) + pe) <<< 1;
      end
      CK_CUBIC: begin
        coef_d.k1 = ((pa - ps) <<< 2) + ((pa - ps) <<< 1);
        d2        = ps - (pa <<< 1) + pb;
        coef_d.k2 = (d2 <<< 2) + (d2 <<< 1);
        coef_d.k3 = (pa3 - pb3 + pe - ps) <<< 1;
      end
      CK_CATMULL: begin
        coef_d.k1 = pe - pa;
        coef_d.k2 = (pa <<< 1) - ((ps <<< 2) + ps) + (pe <<< 2) - pb;
        coef_d.k3 = ps3 - pe3 + pb - pa;
      end
      default: begin
        coef_d.k1 = '0;
      end
    endcase
    coef_d.t        = param_t_i[T_FRAC_BITS-1:0];
    // Curve ends bypass the polynomial
    coef_d.special  = (param_t_i == '0) || param_t_i[T_FRAC_BITS];
    coef_d.spec_val = param_t_i[T_FRAC_BITS] ? pt_end_i : pt_start_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  assign valid_o = valid_q;
  assign coef_o  = coef_q;

endmodule

@@ rtl/pcpe_horner.sv @@
module pcpe_horner import pcpe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  coef_t coef_i,
  output logic  valid_o,
  output poly_t poly_o
);

  logic                 v_acc [0:3];
  logic signed [AW-1:0] acc   [0:3];
  coef_t                side  [0:3];

  assign v_acc[0] = valid_i;
  assign acc[0]   = {{(AW - KW){coef_i.k3[KW-1]}}, coef_i.k3};
  assign side[0]  = coef_i;

  for (genvar j = 0; j < 3; j++) begin : g_step
    logic                                  mv_q, av_q;
    logic [AH+T_FRAC_BITS-1:0]             plo_q;
    logic signed [AW-AH+T_FRAC_BITS:0]     phi_q;
    coef_t                                 mside_q, aside_q;
    logic signed [KW-1:0]                  kadd;
    logic [AW-1:0]                         kx;
    logic [AW-1:0]                         acc_d;
    logic signed [AW-1:0]                  acc_q;

    // Pick the coefficient that enters at this Horner step
    always_comb begin
      case (j)
        0:       kadd = mside_q.k2;
        1:       kadd = mside_q.k1;
        default: kadd = mside_q.k0;
      endcase
      kx    = {{(AW - KW){kadd[KW-1]}}, kadd} << (T_FRAC_BITS * (j + 1));
      acc_d = {phi_q[AW-AH-1:0], {AH{1'b0}}}
            + {{(AW - AH - T_FRAC_BITS){1'b0}}, plo_q}
            + kx;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mv_q <= 1'b0;
        av_q <= 1'b0;
      end else begin
        mv_q <= v_acc[j];
        av_q <= mv_q;
      end
    end

    // Multiply stage: two narrow partial products of acc * t
    always_ff @(posedge clk_i) begin
      plo_q   <= acc[j][AH-1:0] * side[j].t;
      phi_q   <= $signed(acc[j][AW-1:AH]) * $signed({1'b0, side[j].t});
      mside_q <= side[j];
    end

    // Add stage: recombine and add the scaled coefficient
    always_ff @(posedge clk_i) begin
      acc_q   <= acc_d;
      aside_q <= mside_q;
    end

    assign v_acc[j+1] = av_q;
    assign acc[j+1]   = acc_q;
    assign side[j+1]  = aside_q;
  end

  assign valid_o         = v_acc[3];
  assign poly_o.acc      = acc[3];
  assign poly_o.special  = side[3].special;
  assign poly_o.spec_val = side[3].spec_val;

endmodule

@@ rtl/pcpe_round.sv @@
module pcpe_round import pcpe_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  poly_t                         poly_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] coord_o,
  output logic                          sat_o
);

  logic [AW-1:0]                 sum;
  logic [QW-1:0]                 q;
  logic [QW-COORD_WIDTH:0]       top;
  logic                          ovf;
  logic signed [COORD_WIDTH-1:0] coord_d, coord_q;
  logic                          sat_d, sat_q, done_q;

  always_comb begin
    // Round half up, then drop the 2 * S^3 scale
    sum = poly_i.acc + ({{(AW - 1){1'b0}}, 1'b1} << (SH - 1));
    q   = sum[AW-1:SH];
    top = q[QW-1:COORD_WIDTH-1];
    ovf = (top != '0) && (top != '1);
    if (poly_i.special) begin
      coord_d = poly_i.spec_val;
      sat_d   = 1'b0;
    end else if (ovf) begin
      coord_d = q[QW-1] ? {1'b1, {(COORD_WIDTH - 1){1'b0}}}
                        : {1'b0, {(COORD_WIDTH - 1){1'b1}}};
      sat_d   = 1'b1;
    end else begin
      coord_d = q[COORD_WIDTH-1:0];
      sat_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    coord_q <= coord_d;
    sat_q   <= sat_d;
  end

  assign done_o  = done_q;
  assign coord_o = coord_q;
  assign sat_o   = sat_q;

endmodule

@@ rtl/parametric_curve_point_eval_core.sv @@
// Curve point evaluator, one coordinate axis per transaction. Raise start_i for a cycle with
// the curve kind (line, quadratic Bezier, cubic Bezier, Catmull-Rom), t in unsigned Q1.16
// and the four points; busy_o never rises, so a new transaction may enter every clock cycle.
// Each result appears on coord_out_o and saturated_o for exactly one cycle with done_o high,
// in order; the receiver cannot stall and must take it then. The pipeline has one
// coefficient stage, three Horner steps of two stages each (a split multiply of the
// accumulator by t, then a recombining add), and a rounding stage. t of zero returns the
// start point and t of 1.0 or above returns the end point, both with saturated_o low;
// otherwise the result is rounded to nearest (ties up) and clamped to the 32-bit signed
// range, with saturated_o marking a clamp.
module parametric_curve_point_eval_core import pcpe_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    curve_kind_i,
  input  logic [T_FRAC_BITS:0]          param_t_i,
  input  logic signed [COORD_WIDTH-1:0] pt_start_i,
  input  logic signed [COORD_WIDTH-1:0] pt_ctrl_a_i,
  input  logic signed [COORD_WIDTH-1:0] pt_ctrl_b_i,
  input  logic signed [COORD_WIDTH-1:0] pt_end_i,
  output logic                          done_o,
  output logic signed [COORD_WIDTH-1:0] coord_out_o,
  output logic                          saturated_o
);

  logic  coef_valid, poly_valid;
  coef_t coef;
  poly_t poly;

  // The pipeline always advances, so a transaction is never refused
  assign busy_o = 1'b0;

  // Form the doubled power-basis coefficients and flag the curve ends
  pcpe_coef u_coef (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (start_i),
    .curve_kind_i (curve_kind_i),
    .param_t_i    (param_t_i),
    .pt_start_i   (pt_start_i),
    .pt_ctrl_a_i  (pt_ctrl_a_i),
    .pt_ctrl_b_i  (pt_ctrl_b_i),
    .pt_end_i     (pt_end_i),
    .valid_o      (coef_valid),
    .coef_o       (coef)
  );

  // Evaluate the cubic exactly by Horner's rule
  pcpe_horner u_horner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (coef_valid),
    .coef_i  (coef),
    .valid_o (poly_valid),
    .poly_o  (poly)
  );

  // Scale, round, clamp and present the result
  pcpe_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (poly_valid),
    .poly_i  (poly),
    .done_o  (done_o),
    .coord_o (coord_out_o),
    .sat_o   (saturated_o)
  );

endmodule
